// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the indexed shift list RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define ISL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("indexed_shift_list: assertion failed");

// Clocked on clk_i, also checked during reset.
`define ISL_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("indexed_shift_list: assertion failed");

`endif

// File: hw/rtl/isl_pkg.sv
// ----------------------------------------------------------------------------
// isl_pkg
// Types and constants shared by the indexed shift list modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package isl_pkg;

  localparam int unsigned DepthDef = 16;
  localparam int unsigned WidthDef = 32;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned LOC_W  = 5;
  localparam int unsigned ITEM_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned CAP_W  = 5;
  // cell position field, wide enough for the largest supported depth
  localparam int unsigned POS_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_AT    = 3'd2,
    FN_REM_FRONT = 3'd3,
    FN_REM_BACK  = 3'd4,
    FN_MODIFY_AT = 3'd5,
    FN_READ_AT   = 3'd6
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT_DOWN,
    CELL_WRITE
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic [POS_W-1:0]   pos;
  } cell_ctrl_t;

endpackage

// File: hw/rtl/isl_cell.sv
// ----------------------------------------------------------------------------
// isl_cell
// One list element: holds, takes its lower neighbor, its upper neighbor or
// the new item, as the broadcast control says.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isl_cell import isl_pkg::*; #(
  parameter int unsigned WIDTH = WidthDef,
  parameter int unsigned Idx   = 0
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [WIDTH-1:0] prev_i,
  input  logic [WIDTH-1:0] next_i,
  input  logic [WIDTH-1:0] item_i,
  output logic [WIDTH-1:0] data_o
);

  localparam logic [POS_W-1:0] MyPos = POS_W'(Idx);

  logic [WIDTH-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (MyPos == ctrl_i.pos) begin
          data_d = item_i;
        end else if (MyPos > ctrl_i.pos) begin
          data_d = prev_i;
        end
      end
      CELL_SHIFT_DOWN: begin
        data_d = next_i;
      end
      CELL_WRITE: begin
        if (MyPos == ctrl_i.pos) begin
          data_d = item_i;
        end
      end
      CELL_HOLD: begin
        data_d = data_q;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: hw/rtl/isl_chain.sv
// ----------------------------------------------------------------------------
// isl_chain
// Row of DEPTH cells linked to their neighbors, with the indexed read select.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module isl_chain import isl_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned WIDTH = WidthDef
) (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic [WIDTH-1:0]         item_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  output logic [WIDTH-1:0]         front_o
);

  logic [WIDTH-1:0] data [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WIDTH-1:0] prev, next;

    if (g == 0) begin : g_first
      assign prev = '0;
    end else begin : g_prev
      assign prev = data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next = '0;
    end else begin : g_next
      assign next = data[g+1];
    end

    isl_cell #(
      .WIDTH (WIDTH),
      .Idx   (g)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .prev_i (prev),
      .next_i (next),
      .item_i (item_i),
      .data_o (data[g])
    );
  end

  assign rd_data_o = data[rd_addr_i];
  assign front_o   = data[0];

endmodule

// File: hw/rtl/indexed_shift_list.sv
// ----------------------------------------------------------------------------
// indexed_shift_list
// Ordered list with insert/remove/modify/read by position, built as a row
// of shifting cells, with a registered result.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o func_i, location_i, item_in_i
//  out      output     out_valid_o/ out_stall_i item_out_o, status_o, count_o
//  cfg      input      cfg_we_i                cfg_data_i (capacity)
//
// One request per cycle while in_stall_o is low: the cell row updates its
// elements and the result lands in the output register on the same edge.
// in_stall_o is high only while a result is held and out_stall_i is high.
// Reset empties the list (count 0) and sets capacity to 16; element
// contents are undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_shift_list import isl_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned WIDTH = WidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [LOC_W-1:0]  location_i,
  input  logic [ITEM_W-1:0] item_in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ITEM_W-1:0] item_out_o,
  output logic [STAT_W-1:0] status_o,
  output logic [CNT_W-1:0]  count_o
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CmpW  = (CntW > LOC_W) ? CntW : LOC_W;
  localparam int unsigned AddrW = $clog2(DEPTH);

  logic [CntW-1:0]   fill_d, fill_q;
  logic [CAP_W-1:0]  cap_q;
  logic              out_valid_q;
  logic [ITEM_W-1:0] item_out_q;
  status_e           status_d, status_q;
  logic [CNT_W-1:0]  count_q;

  logic              in_acc;
  logic [CmpW-1:0]   fill_c, loc_c, cap_c, cap_eff, rd_addr_c;
  logic              full;
  logic              take_front, take_rd;
  cell_ctrl_t        ctrl_c, cell_ctrl;
  logic [WIDTH-1:0]  rd_data, front, got;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  always_comb begin
    fill_c = CmpW'(fill_q);
    loc_c  = CmpW'(location_i);
    cap_c  = CmpW'(cap_q);
    if (cap_c == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_c > CmpW'(DEPTH)) begin
      cap_eff = CmpW'(DEPTH);
    end else begin
      cap_eff = cap_c;
    end
    full = (fill_c >= cap_eff);
  end

  // request decode
  always_comb begin
    ctrl_c.op  = CELL_HOLD;
    ctrl_c.pos = '0;
    status_d   = ST_OK;
    fill_d     = fill_q;
    take_front = 1'b0;
    take_rd    = 1'b0;
    rd_addr_c  = loc_c;
    unique case (func_e'(func_i))
      FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (func_e'(func_i) == FN_INS_AT && loc_c > fill_c) begin
          status_d = ST_BAD;
        end else begin
          ctrl_c.op = CELL_INSERT;
          if (func_e'(func_i) == FN_INS_FRONT) begin
            ctrl_c.pos = '0;
          end else if (func_e'(func_i) == FN_INS_BACK) begin
            ctrl_c.pos = POS_W'(fill_c);
          end else begin
            ctrl_c.pos = POS_W'(loc_c);
          end
          fill_d = fill_q + CntW'(1);
        end
      end
      FN_REM_FRONT: begin
        if (fill_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl_c.op  = CELL_SHIFT_DOWN;
          take_front = 1'b1;
          fill_d     = fill_q - CntW'(1);
        end
      end
      FN_REM_BACK: begin
        rd_addr_c = fill_c - CmpW'(1);
        if (fill_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          take_rd = 1'b1;
          fill_d  = fill_q - CntW'(1);
        end
      end
      FN_MODIFY_AT: begin
        if (loc_c >= fill_c) begin
          status_d = ST_BAD;
        end else begin
          ctrl_c.op  = CELL_WRITE;
          ctrl_c.pos = POS_W'(loc_c);
        end
      end
      FN_READ_AT: begin
        if (loc_c >= fill_c) begin
          status_d = ST_BAD;
        end else begin
          take_rd = 1'b1;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_comb begin
    cell_ctrl     = ctrl_c;
    cell_ctrl.op  = in_acc ? ctrl_c.op : CELL_HOLD;
    if (take_front) begin
      got = front;
    end else if (take_rd) begin
      got = rd_data;
    end else begin
      got = '0;
    end
  end

  isl_chain #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_chain (
    .clk_i     (clk_i),
    .ctrl_i    (cell_ctrl),
    .item_i    (WIDTH'(item_in_i)),
    .rd_addr_i (rd_addr_c[AddrW-1:0]),
    .rd_data_o (rd_data),
    .front_o   (front)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (in_acc) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_out_q <= ITEM_W'(got);
      status_q   <= status_d;
      count_q    <= CNT_W'(fill_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_out_o  = item_out_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

  `ISL_ASSERT(a_fill_bound, fill_q <= CntW'(DEPTH))
  `ISL_ASSERT(a_acc_gives_result, in_acc |=> out_valid_q)
  `ISL_ASSERT(a_insert_grows, cell_ctrl.op == CELL_INSERT |=> fill_q == $past(fill_q) + CntW'(1))
  `ISL_ASSERT(a_shift_shrinks, cell_ctrl.op == CELL_SHIFT_DOWN |=> fill_q == $past(fill_q) - CntW'(1))
  `ISL_ASSERT(a_full_only_at_cap, (in_acc && status_d == ST_FULL) |-> (fill_c >= cap_eff))

endmodule

// File: tb/indexed_shift_list_tb.sv
// ----------------------------------------------------------------------------
// indexed_shift_list_tb
// Self-checking bench for the indexed shift list. A short stimulus table hits
// the empty, full and bad-location cases and the capacity limits. Random
// phases then run under different capacities. Each transfer is predicted by
// a shadow list and checked against the results in order. Both channels idle
// at random. One phase holds the output off for a long time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_shift_list_tb;
  import isl_pkg::*;

  localparam int unsigned LIST_DEPTH    = DepthDef;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_ITEMS   = 130;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;

  // spare func code, the block answers ok and does nothing
  localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;
  localparam logic [FUNC_W-1:0] INS_CODES [3] = '{FN_INS_FRONT, FN_INS_BACK, FN_INS_AT};

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  typedef struct packed {
    logic              cfg;    // row is a capacity write
    logic [CAP_W-1:0]  cap;
    logic [FUNC_W-1:0] fn;
    logic [LOC_W-1:0]  loc;
    logic [ITEM_W-1:0] val;
    logic              typed;  // res holds the expected result
    list_result_t      res;
  } dir_row_t;

  localparam int unsigned NUM_DIR = 26;
  localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
    '{1'b0, '0, FN_READ_AT,   5'd0,  '0,           1'b1, '{'0, ST_BAD, 5'd0}},
    '{1'b0, '0, FN_REM_FRONT, 5'd0,  '0,           1'b1, '{'0, ST_EMPTY, 5'd0}},
    '{1'b0, '0, FN_REM_BACK,  5'd0,  '0,           1'b1, '{'0, ST_EMPTY, 5'd0}},
    '{1'b0, '0, FN_MODIFY_AT, 5'd0,  32'h1,        1'b1, '{'0, ST_BAD, 5'd0}},
    '{1'b0, '0, FN_SPARE,     5'd0,  32'h77,       1'b1, '{'0, ST_OK, 5'd0}},
    '{1'b0, '0, FN_INS_AT,    5'd1,  32'h5,        1'b1, '{'0, ST_BAD, 5'd0}},
    '{1'b0, '0, FN_INS_AT,    5'd0,  32'hFFFFFFFF, 1'b1, '{'0, ST_OK, 5'd1}},
    '{1'b0, '0, FN_INS_FRONT, 5'd0,  32'h0,        1'b1, '{'0, ST_OK, 5'd2}},
    '{1'b0, '0, FN_INS_BACK,  5'd31, 32'hA5A5A5A5, 1'b1, '{'0, ST_OK, 5'd3}},
    '{1'b0, '0, FN_INS_AT,    5'd1,  32'h12345678, 1'b0, '0},
    '{1'b0, '0, FN_READ_AT,   5'd31, '0,           1'b1, '{'0, ST_BAD, 5'd4}},
    '{1'b0, '0, FN_INS_AT,    5'd31, 32'h9,        1'b1, '{'0, ST_BAD, 5'd4}},
    '{1'b0, '0, FN_MODIFY_AT, 5'd3,  32'hDEADBEEF, 1'b0, '0},
    '{1'b0, '0, FN_READ_AT,   5'd3,  '0,           1'b1, '{32'hDEADBEEF, ST_OK, 5'd4}},
    '{1'b0, '0, FN_REM_FRONT, 5'd0,  '0,           1'b0, '0},
    '{1'b0, '0, FN_REM_BACK,  5'd0,  '0,           1'b0, '0},
    // capacity 0 acts as 1, below the current length of 2
    '{1'b1, 5'd0, '0,         '0,    '0,           1'b0, '0},
    '{1'b0, '0, FN_INS_FRONT, 5'd0,  32'h3,        1'b1, '{'0, ST_FULL, 5'd2}},
    '{1'b0, '0, FN_INS_AT,    5'd31, 32'h4,        1'b1, '{'0, ST_FULL, 5'd2}},
    '{1'b0, '0, FN_READ_AT,   5'd1,  '0,           1'b0, '0},
    '{1'b0, '0, FN_REM_BACK,  5'd0,  '0,           1'b0, '0},
    '{1'b0, '0, FN_INS_BACK,  5'd0,  32'h6,        1'b1, '{'0, ST_FULL, 5'd1}},
    '{1'b0, '0, FN_REM_FRONT, 5'd0,  '0,           1'b0, '0},
    '{1'b0, '0, FN_INS_AT,    5'd0,  32'h5A5A5A5A, 1'b1, '{'0, ST_OK, 5'd1}},
    // capacity 31 acts as the full depth
    '{1'b1, 5'd31, '0,        '0,    '0,           1'b0, '0},
    '{1'b0, '0, FN_REM_BACK,  5'd0,  '0,           1'b1, '{32'h5A5A5A5A, ST_OK, 5'd0}}
  };

  localparam logic [CAP_W-1:0] CAP_PLAN [NUM_PHASES] = '{
    5'd16, 5'd1, 5'd31, 5'd0, 5'd2, 5'd0, 5'd16, 5'd0, 5'd8, 5'd16
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic [CAP_W-1:0]  cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [FUNC_W-1:0] func_i      = '0;
  logic [LOC_W-1:0]  location_i  = '0;
  logic [ITEM_W-1:0] item_in_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ITEM_W-1:0] item_out_o;
  logic [STAT_W-1:0] status_o;
  logic [CNT_W-1:0]  count_o;

  // shadow copy of the list
  logic [ITEM_W-1:0] list_mem [LIST_DEPTH];
  int unsigned       list_len   = 0;
  logic [CAP_W-1:0]  cap_shadow = CAP_RESET;

  list_result_t pending_results [$];
  int unsigned  mismatch_cnt  = 0;
  int unsigned  cycle_cnt     = 0;
  bit           tx_quiet      = 1'b0;
  bit           rx_quiet      = 1'b0;
  int unsigned  long_hold_req = 0;

  indexed_shift_list u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .location_i  (location_i),
    .item_in_i   (item_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_out_o  (item_out_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // open a slot at pos, later elements move up one place
  function automatic void open_slot(int unsigned pos, logic [ITEM_W-1:0] val);
    for (int unsigned i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
    list_mem[pos] = val;
    list_len++;
  endfunction

  function automatic list_result_t apply_request(logic [FUNC_W-1:0] fn,
                                                 logic [LOC_W-1:0] loc,
                                                 logic [ITEM_W-1:0] val);
    list_result_t res;
    int unsigned  lim;
    bit           full;
    res  = '{item: '0, status: ST_OK, count: '0};
    lim  = (cap_shadow == 0) ? 1 : ((cap_shadow > LIST_DEPTH) ? LIST_DEPTH : cap_shadow);
    full = (list_len >= lim);
    case (fn)
      FN_INS_FRONT: begin
        if (full) res.status = ST_FULL;
        else open_slot(0, val);
      end
      FN_INS_BACK: begin
        if (full) res.status = ST_FULL;
        else open_slot(list_len, val);
      end
      FN_INS_AT: begin
        // full wins over a bad location
        if (full) res.status = ST_FULL;
        else if (loc > list_len) res.status = ST_BAD;
        else open_slot(loc, val);
      end
      FN_REM_FRONT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else begin
          res.item = list_mem[0];
          for (int unsigned i = 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
          list_len--;
        end
      end
      FN_REM_BACK: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else begin
          list_len--;
          res.item = list_mem[list_len];
        end
      end
      FN_MODIFY_AT: begin
        if (loc >= list_len) res.status = ST_BAD;
        else list_mem[loc] = val;
      end
      FN_READ_AT: begin
        if (loc >= list_len) res.status = ST_BAD;
        else res.item = list_mem[loc];
      end
      default: ;
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_req(logic [FUNC_W-1:0] fn, logic [LOC_W-1:0] loc,
                          logic [ITEM_W-1:0] val, bit typed, list_result_t typed_res);
    int unsigned  gap;
    list_result_t pred;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= fn;
    location_i <= loc;
    item_in_i  <= val;
    do @(posedge clk_i); while (in_stall_o);
    pred = apply_request(fn, loc, val);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  // stop offering and wait for the block to go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cap_shadow = val;
  endtask

  task automatic check_result(list_result_t got);
    list_result_t want;
    if (pending_results.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("%0t: result with nothing pending: item %h status %0d count %0d",
                 $realtime, got.item, got.status, got.count);
    end else begin
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t: mismatch: item %h/%h status %0d/%0d count %0d/%0d (exp/act)",
                   $realtime, want.item, got.item, want.status, got.status,
                   want.count, got.count);
      end
    end
  endtask

  // output side: random stall before each transfer, or one long hold on request
  initial begin : rx_side
    int unsigned  waits;
    int unsigned  holds_done;
    list_result_t got;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req > holds_done) begin
        holds_done++;
        waits = LONG_HOLD;
      end else begin
        waits = rx_quiet ? 0 : $urandom_range(0, 10);
      end
      if (waits > 0) begin
        out_stall_i <= 1'b1;
        repeat (waits) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      got = '{item: item_out_o, status: status_o, count: count_o};
      check_result(got);
    end
  end

  initial begin : stimulus
    dir_row_t          row;
    logic [FUNC_W-1:0] fn;
    logic [LOC_W-1:0]  loc;
    logic [CAP_W-1:0]  cap;
    int unsigned       r;
    int unsigned       ins_pct;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned d = 0; d < NUM_DIR; d++) begin
      row = DIR_TABLE[d];
      if (row.cfg) begin
        settle();
        write_capacity(row.cap);
      end else begin
        send_req(row.fn, row.loc, row.val, row.typed, row.res);
      end
    end

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      // a couple of phases take a random capacity over the whole field
      cap = (ph == 5 || ph == 7) ? CAP_W'($urandom_range(0, 31)) : CAP_PLAN[ph];
      write_capacity(cap);
      tx_quiet = (ph == 3);
      rx_quiet = (ph == 3);
      if (ph == 5) long_hold_req++;
      ins_pct = (ph % 3 == 0) ? 65 : ((ph % 3 == 1) ? 25 : 45);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 6 && n == PHASE_ITEMS / 2) settle();
        r = $urandom_range(0, 99);
        if (r < ins_pct) fn = INS_CODES[$urandom_range(0, 2)];
        else if (r < 80) fn = r[0] ? FN_REM_FRONT : FN_REM_BACK;
        else if (r < 88) fn = FN_MODIFY_AT;
        else if (r < 97) fn = FN_READ_AT;
        else fn = FN_SPARE;
        // mostly legal locations, some anywhere in the field
        if ($urandom_range(0, 7) == 0) loc = LOC_W'($urandom_range(0, 31));
        else if (fn == FN_INS_AT) loc = LOC_W'($urandom_range(0, list_len));
        else if ((fn == FN_MODIFY_AT || fn == FN_READ_AT) && list_len > 0)
          loc = LOC_W'($urandom_range(0, list_len - 1));
        else loc = LOC_W'($urandom_range(0, 31));
        send_req(fn, loc, $urandom(), 1'b0, '0);
      end
    end

    settle();
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
